>>> src/rrd_pkg.sv
package rrd_pkg;

  localparam logic OpReflect = 1'b0;
  localparam logic OpRefract = 1'b1;

  localparam logic [14:0] IdxMin      = 15'd1024;
  localparam logic [15:0] OffsetReset = 16'd168;

  // iteration counts of the stepped units
  localparam int EdivN = 19;  // eta quotient bits
  localparam int SqkN  = 15;  // root bits of k
  localparam int NormN = 9;   // right 8,4,2,1 then left 16,8,4,2,1
  localparam int SqlN  = 31;  // root bits of the length
  localparam int DivN  = 15;  // quotient bits of each component

  // stage map
  localparam int StProd  = 0;
  localparam int StDot   = StProd + 1;
  localparam int StEdiv  = StDot + 1;
  localparam int StEta   = StEdiv + EdivN;
  localparam int StMul1  = StEta + 1;
  localparam int StRnd1  = StMul1 + 1;
  localparam int StMul2  = StRnd1 + 1;
  localparam int StK     = StMul2 + 1;
  localparam int StSqk   = StK + 1;
  localparam int StCoef  = StSqk + SqkN;
  localparam int StMul3  = StCoef + 1;
  localparam int StVsel  = StMul3 + 1;
  localparam int StAbs   = StVsel + 1;
  localparam int StMax   = StAbs + 1;
  localparam int StNorm  = StMax + 1;
  localparam int StSqr   = StNorm + NormN;
  localparam int StSum   = StSqr + 1;
  localparam int StSql   = StSum + 1;
  localparam int StDinit = StSql + SqlN;
  localparam int StDiv   = StDinit + 1;
  localparam int StSign  = StDiv + DivN;
  localparam int StOmul  = StSign + 1;
  localparam int StOrnd  = StOmul + 1;
  localparam int StOadd  = StOrnd + 1;
  localparam int NStage  = StOadd + 1;

  typedef struct {
    logic               op;
    logic signed [15:0] d [3];
    logic signed [15:0] n [3];
    logic signed [39:0] h [3];
    logic [14:0]        idx;
    logic signed [31:0] prod [3];
    logic signed [33:0] dot;
    logic [28:0]        eta_num;
    logic [14:0]        eta_rem;
    logic [18:0]        eta_quo;
    logic               leave;
    logic [18:0]        eta;
    logic [14:0]        c;
    logic signed [19:0] dq;
    logic [37:0]        eta_sq;
    logic [28:0]        c_sq;
    logic [32:0]        etac;
    logic signed [34:0] etad [3];
    logic signed [35:0] dqn [3];
    logic [21:0]        eta2;
    logic [14:0]        s2;
    logic [16:0]        etac_r;
    logic signed [18:0] ed [3];
    logic signed [39:0] refl [3];
    logic [35:0]        tprod;
    logic signed [21:0] k;
    logic               tir;
    logic [28:0]        sx;
    logic [28:0]        sr;
    logic signed [18:0] coef;
    logic signed [16:0] nsel [3];
    logic signed [35:0] cn [3];
    logic signed [39:0] v [3];
    logic [39:0]        m [3];
    logic               neg [3];
    logic [39:0]        mx;
    logic               zero;
    logic [59:0]        sqm [3];
    logic [61:0]        lx;
    logic [61:0]        lr;
    logic [30:0]        len;
    logic [44:0]        dnum [3];
    logic [30:0]        drem [3];
    logic [14:0]        dquo [3];
    logic signed [15:0] nd [3];
    logic signed [32:0] offp [3];
    logic signed [18:0] off [3];
    logic signed [39:0] o [3];
  } pipe_t;

endpackage

>>> src/ray_reflect_refract_direction.sv
// Reflect / refract direction unit.
// Request channel: drive opcode, dir_*, norm_*, hit_*, refr_index and pulse start;
// a request is taken at each rising edge with start high and busy low. busy is
// always low, so one request can be taken every cycle.
// Result channel: done is high for exactly one cycle with new_dir_*,
// new_origin_* and total_reflection; the receiver must take it then.
// Results leave in request order; done rises once a request has passed the input
// register and every stage of the pipe. Throughput: one request per cycle, fixed.
// Among the stages of the pipe are stepped units: a 19-stage divider for
// 1/index, a 15-stage root for k, 9 normalizing shift stages, a 31-stage root
// for the vector length and three 15-stage dividers for the components.
// Config: cfg_valid/cfg_ready/cfg_data writes origin_offset (cfg_ready is always
// high); write it only while no request is in flight.
// Reset (rst, synchronous): drops every request in flight, sets origin_offset
// to 168. There is no output backpressure.
module ray_reflect_refract_direction (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  output logic               busy,
  input  logic               opcode,
  input  logic signed [15:0] dir_x,
  input  logic signed [15:0] dir_y,
  input  logic signed [15:0] dir_z,
  input  logic signed [15:0] norm_x,
  input  logic signed [15:0] norm_y,
  input  logic signed [15:0] norm_z,
  input  logic signed [39:0] hit_x,
  input  logic signed [39:0] hit_y,
  input  logic signed [39:0] hit_z,
  input  logic [14:0]        refr_index,
  output logic               done,
  output logic signed [15:0] new_dir_x,
  output logic signed [15:0] new_dir_y,
  output logic signed [15:0] new_dir_z,
  output logic signed [39:0] new_origin_x,
  output logic signed [39:0] new_origin_y,
  output logic signed [39:0] new_origin_z,
  output logic               total_reflection,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [15:0]        cfg_data
);

  function automatic rrd_pkg::pipe_t stage_fn(input int s, input rrd_pkg::pipe_t p,
                                              input logic [15:0] ofs);
    rrd_pkg::pipe_t     q;
    int                 i;
    int                 j;
    int                 sh;
    logic [15:0]        erem2;
    logic signed [33:0] adot;
    logic signed [33:0] rdq;
    logic signed [33:0] rc;
    logic [19:0]        cw;
    logic [37:0]        t38;
    logic [28:0]        t29;
    logic [32:0]        t33u;
    logic signed [34:0] t35;
    logic [35:0]        t36;
    logic [19:0]        tt;
    logic [28:0]        kbit;
    logic [29:0]        ktrial;
    logic signed [39:0] vr;
    logic [39:0]        mxv;
    logic [61:0]        lbit;
    logic [62:0]        ltrial;
    logic [31:0]        drem2;
    logic signed [32:0] t33s;
    logic signed [40:0] osum;
    q = p;
    if (s == rrd_pkg::StProd) begin
      for (i = 0; i < 3; i++) q.prod[i] = 32'(p.d[i]) * 32'(p.n[i]);
      q.eta_num = {1'b1, 28'd0} + {15'd0, p.idx[14:1]};
      q.eta_rem = 15'(q.eta_num >> rrd_pkg::EdivN);
      q.eta_quo = '0;
    end else if (s == rrd_pkg::StDot) begin
      q.dot = 34'(p.prod[0]) + 34'(p.prod[1]) + 34'(p.prod[2]);
    end else if (s < rrd_pkg::StEta) begin
      j = s - rrd_pkg::StEdiv;
      erem2 = {p.eta_rem, p.eta_num[rrd_pkg::EdivN - 1 - j]};
      if (erem2 >= {1'b0, p.idx}) begin
        q.eta_rem = 15'(erem2 - {1'b0, p.idx});
        q.eta_quo = {p.eta_quo[17:0], 1'b1};
      end else begin
        q.eta_rem = erem2[14:0];
        q.eta_quo = {p.eta_quo[17:0], 1'b0};
      end
    end else if (s == rrd_pkg::StEta) begin
      q.leave = (p.dot > 34'sd0);
      q.eta = q.leave ? {p.idx, 4'd0} : p.eta_quo;
      adot = p.dot[33] ? -p.dot : p.dot;
      rc = adot + 34'sd8192;
      cw = rc[33:14];
      q.c = (cw > 20'd16384) ? 15'd16384 : cw[14:0];
      rdq = p.dot + 34'sd8192 - 34'(p.dot[33]);
      q.dq = rdq[33:14];
    end else if (s == rrd_pkg::StMul1) begin
      q.eta_sq = 38'(p.eta) * 38'(p.eta);
      q.c_sq = 29'(p.c) * 29'(p.c);
      q.etac = 33'(p.eta) * 33'(p.c);
      for (i = 0; i < 3; i++) begin
        q.etad[i] = $signed({16'd0, p.eta}) * 35'(p.d[i]);
        q.dqn[i] = 36'(p.dq) * 36'(p.n[i]);
      end
    end else if (s == rrd_pkg::StRnd1) begin
      t38 = p.eta_sq + 38'd32768;
      q.eta2 = t38[37:16];
      t29 = {1'b1, 28'd0} - p.c_sq + 29'd8192;
      q.s2 = t29[28:14];
      t33u = p.etac + 33'd32768;
      q.etac_r = t33u[32:16];
      for (i = 0; i < 3; i++) begin
        t35 = p.etad[i] + 35'sd32768 - 35'(p.etad[i][34]);
        q.ed[i] = t35[34:16];
        q.refl[i] = (40'(p.d[i]) <<< 14) - (40'(p.dqn[i]) <<< 1);
      end
    end else if (s == rrd_pkg::StMul2) begin
      q.tprod = 36'(p.eta2) * 36'(p.s2);
    end else if (s == rrd_pkg::StK) begin
      t36 = p.tprod + 36'd32768;
      tt = t36[35:16];
      q.k = 22'sd16384 - $signed({2'b0, tt});
      q.tir = (p.op == rrd_pkg::OpRefract) && q.k[21];
      q.sx = q.k[21] ? 29'd0 : {q.k[14:0], 14'd0};
      q.sr = '0;
    end else if (s < rrd_pkg::StCoef) begin
      j = s - rrd_pkg::StSqk;
      kbit = 29'(1) << (2 * (rrd_pkg::SqkN - 1 - j));
      ktrial = 30'(p.sr) + 30'(kbit);
      if (30'(p.sx) >= ktrial) begin
        q.sx = 29'(30'(p.sx) - ktrial);
        q.sr = (p.sr >> 1) + kbit;
      end else begin
        q.sr = p.sr >> 1;
      end
    end else if (s == rrd_pkg::StCoef) begin
      q.coef = $signed({2'b0, p.etac_r}) - $signed({4'b0, p.sr[14:0]});
      for (i = 0; i < 3; i++) q.nsel[i] = p.leave ? -17'(p.n[i]) : 17'(p.n[i]);
    end else if (s == rrd_pkg::StMul3) begin
      for (i = 0; i < 3; i++) q.cn[i] = 36'(p.coef) * 36'(p.nsel[i]);
    end else if (s == rrd_pkg::StVsel) begin
      for (i = 0; i < 3; i++) begin
        vr = (40'(p.ed[i]) <<< 14) + 40'(p.cn[i]);
        q.v[i] = (p.op == rrd_pkg::OpRefract && !p.tir) ? vr : p.refl[i];
      end
    end else if (s == rrd_pkg::StAbs) begin
      for (i = 0; i < 3; i++) begin
        q.neg[i] = p.v[i][39];
        q.m[i] = p.v[i][39] ? 40'(-p.v[i]) : 40'(p.v[i]);
      end
    end else if (s == rrd_pkg::StMax) begin
      mxv = (p.m[0] > p.m[1]) ? p.m[0] : p.m[1];
      mxv = (mxv > p.m[2]) ? mxv : p.m[2];
      q.mx = mxv;
      q.zero = (mxv == 40'd0);
    end else if (s < rrd_pkg::StSqr) begin
      // bring the largest magnitude into [2^29, 2^30)
      j = s - rrd_pkg::StNorm;
      if (j < 4) begin
        sh = 8 >> j;
        if (p.mx >= (40'(1) << (29 + sh))) begin
          for (i = 0; i < 3; i++) q.m[i] = p.m[i] >> sh;
          q.mx = p.mx >> sh;
        end
      end else begin
        sh = 16 >> (j - 4);
        if (p.mx < (40'(1) << (30 - sh))) begin
          for (i = 0; i < 3; i++) q.m[i] = p.m[i] << sh;
          q.mx = p.mx << sh;
        end
      end
    end else if (s == rrd_pkg::StSqr) begin
      for (i = 0; i < 3; i++) q.sqm[i] = 60'(p.m[i][29:0]) * 60'(p.m[i][29:0]);
    end else if (s == rrd_pkg::StSum) begin
      q.lx = 62'(p.sqm[0]) + 62'(p.sqm[1]) + 62'(p.sqm[2]);
      q.lr = '0;
    end else if (s < rrd_pkg::StDinit) begin
      j = s - rrd_pkg::StSql;
      lbit = 62'(1) << (2 * (rrd_pkg::SqlN - 1 - j));
      ltrial = 63'(p.lr) + 63'(lbit);
      if (63'(p.lx) >= ltrial) begin
        q.lx = 62'(63'(p.lx) - ltrial);
        q.lr = (p.lr >> 1) + lbit;
      end else begin
        q.lr = p.lr >> 1;
      end
    end else if (s == rrd_pkg::StDinit) begin
      q.len = p.lr[30:0];
      for (i = 0; i < 3; i++) begin
        q.dnum[i] = {1'b0, p.m[i][29:0], 14'd0} + {15'd0, q.len[30:1]};
        q.drem[i] = {1'b0, q.dnum[i][44:15]};
        q.dquo[i] = '0;
      end
    end else if (s < rrd_pkg::StSign) begin
      j = s - rrd_pkg::StDiv;
      for (i = 0; i < 3; i++) begin
        drem2 = {p.drem[i], p.dnum[i][rrd_pkg::DivN - 1 - j]};
        if (drem2 >= {1'b0, p.len}) begin
          q.drem[i] = 31'(drem2 - {1'b0, p.len});
          q.dquo[i] = {p.dquo[i][13:0], 1'b1};
        end else begin
          q.drem[i] = drem2[30:0];
          q.dquo[i] = {p.dquo[i][13:0], 1'b0};
        end
      end
    end else if (s == rrd_pkg::StSign) begin
      for (i = 0; i < 3; i++) begin
        if (p.zero) q.nd[i] = '0;
        else if (p.neg[i]) q.nd[i] = -$signed({1'b0, p.dquo[i]});
        else q.nd[i] = $signed({1'b0, p.dquo[i]});
      end
    end else if (s == rrd_pkg::StOmul) begin
      for (i = 0; i < 3; i++) q.offp[i] = 33'(p.nd[i]) * $signed({17'd0, ofs});
    end else if (s == rrd_pkg::StOrnd) begin
      for (i = 0; i < 3; i++) begin
        t33s = p.offp[i] + 33'sd8192 - 33'(p.offp[i][32]);
        q.off[i] = t33s[32:14];
      end
    end else begin
      for (i = 0; i < 3; i++) begin
        osum = 41'(p.h[i]) + 41'(p.off[i]);
        if (osum[40] != osum[39]) q.o[i] = osum[40] ? {1'b1, 39'd0} : {1'b0, {39{1'b1}}};
        else q.o[i] = osum[39:0];
      end
    end
    return q;
  endfunction

  logic [15:0]              origin_offset;
  logic [rrd_pkg::NStage:0] vld;
  rrd_pkg::pipe_t           pipe [rrd_pkg::NStage + 1];

  assign busy = 1'b0;
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      origin_offset <= rrd_pkg::OffsetReset;
    end else if (cfg_valid && cfg_ready) begin
      origin_offset <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      vld <= {vld[rrd_pkg::NStage-1:0], start && !busy};
    end
  end

  always_ff @(posedge clk) begin
    pipe[0].op   <= opcode;
    pipe[0].d[0] <= dir_x;
    pipe[0].d[1] <= dir_y;
    pipe[0].d[2] <= dir_z;
    pipe[0].n[0] <= norm_x;
    pipe[0].n[1] <= norm_y;
    pipe[0].n[2] <= norm_z;
    pipe[0].h[0] <= hit_x;
    pipe[0].h[1] <= hit_y;
    pipe[0].h[2] <= hit_z;
    pipe[0].idx  <= (refr_index < rrd_pkg::IdxMin) ? rrd_pkg::IdxMin : refr_index;
  end

  for (genvar g = 0; g < rrd_pkg::NStage; g++) begin : g_stage
    always_ff @(posedge clk) begin
      pipe[g+1] <= stage_fn(g, pipe[g], origin_offset);
    end
  end

  assign done             = vld[rrd_pkg::NStage];
  assign new_dir_x        = pipe[rrd_pkg::NStage].nd[0];
  assign new_dir_y        = pipe[rrd_pkg::NStage].nd[1];
  assign new_dir_z        = pipe[rrd_pkg::NStage].nd[2];
  assign new_origin_x     = pipe[rrd_pkg::NStage].o[0];
  assign new_origin_y     = pipe[rrd_pkg::NStage].o[1];
  assign new_origin_z     = pipe[rrd_pkg::NStage].o[2];
  assign total_reflection = pipe[rrd_pkg::NStage].tir;

  a_latency: assert property (@(posedge clk) disable iff (rst)
    start && !busy |-> ##(rrd_pkg::NStage + 1) done)
    else $error("request did not come out after the pipe latency");

  a_tir_refract: assert property (@(posedge clk) disable iff (rst)
    done && total_reflection |-> pipe[rrd_pkg::NStage].op == rrd_pkg::OpRefract)
    else $error("total reflection flagged on a reflect request");

  a_zero_dir: assert property (@(posedge clk) disable iff (rst)
    done && pipe[rrd_pkg::NStage].zero |->
      new_dir_x == 16'sd0 && new_dir_y == 16'sd0 && new_dir_z == 16'sd0 &&
      new_origin_x == pipe[rrd_pkg::NStage].h[0] &&
      new_origin_y == pipe[rrd_pkg::NStage].h[1] &&
      new_origin_z == pipe[rrd_pkg::NStage].h[2])
    else $error("zero vector did not keep the hit position");

endmodule
